// File: rtl/sbl_pkg.sv
// shared constants for the sobel edge magnitude block
package sbl_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 1024;
  localparam int ROW_COUNT_BITS_DEF = 12;

  localparam int PIXEL_W    = 8;
  localparam int MAG_W      = 8;
  localparam int MAG_SUM_W  = 11;
  localparam int MAG_MAX    = 255;

  localparam int LINE_WIDTH_RESET = 640;
  localparam int LINE_WIDTH_MIN   = 3;
  localparam int WINDOW_FIRST     = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH = 3'd0;

endpackage

// File: rtl/sbl_ram.sv
// generic single write port ram with registered read
module sbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sbl_window.sv
// 3x3 window cells and sobel l1 magnitude of the shifted window
module sbl_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift,
  input  logic [sbl_pkg::PIXEL_W-1:0] upper,
  input  logic [sbl_pkg::PIXEL_W-1:0] middle,
  input  logic [sbl_pkg::PIXEL_W-1:0] pixel,
  output logic [sbl_pkg::MAG_W-1:0]   magnitude
);

  localparam int PW = sbl_pkg::PIXEL_W;
  localparam int SW = PW + 3;

  logic [PW-1:0] win_r   [9];
  logic [PW-1:0] win_nxt [9];

  logic [SW-1:0]            gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [SW-1:0]     gx, gy;
  logic [SW-1:0]            gx_abs, gy_abs;
  logic [sbl_pkg::MAG_SUM_W-1:0] mag_sum;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3+1];
      win_nxt[r*3 + 1] = win_r[r*3+2];
    end
    win_nxt[2] = upper;
    win_nxt[5] = middle;
    win_nxt[8] = pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    gx_pos = SW'(win_nxt[2]) + {(SW-1)'(win_nxt[5]), 1'b0} + SW'(win_nxt[8]);
    gx_neg = SW'(win_nxt[0]) + {(SW-1)'(win_nxt[3]), 1'b0} + SW'(win_nxt[6]);
    gy_pos = SW'(win_nxt[6]) + {(SW-1)'(win_nxt[7]), 1'b0} + SW'(win_nxt[8]);
    gy_neg = SW'(win_nxt[0]) + {(SW-1)'(win_nxt[1]), 1'b0} + SW'(win_nxt[2]);
    gx     = $signed(gx_pos - gx_neg);
    gy     = $signed(gy_pos - gy_neg);
    gx_abs = gx[SW-1] ? SW'(-gx) : SW'(gx);
    gy_abs = gy[SW-1] ? SW'(-gy) : SW'(gy);
    mag_sum = sbl_pkg::MAG_SUM_W'(gx_abs) + sbl_pkg::MAG_SUM_W'(gy_abs);
    if (mag_sum > sbl_pkg::MAG_SUM_W'(sbl_pkg::MAG_MAX)) begin
      magnitude = sbl_pkg::MAG_W'(sbl_pkg::MAG_MAX);
    end else begin
      magnitude = mag_sum[sbl_pkg::MAG_W-1:0];
    end
  end

endmodule

// File: rtl/sobel_edge_magnitude.sv
// top level of the 3x3 sobel edge magnitude block
//
//  port group | dir | payload                                   | marker
//  in_        | in  | tdata: pixel                              | tuser: frame_start
//  out_       | out | tdata: edge_magnitude, centre_column, row | none
//  cfg_       | in  | apb write/read of line_width at 0x0       | none
//
// one pixel per clock unless the output stalls; a result passes the window stage and the result register
// the two line store rams are read at transfer and written one stage later
// reset clears counters, window cells and valid flags; line stores stay unset
// a stalled result register holds a window stage that carries a result, which then holds the input
module sobel_edge_magnitude #(
  parameter int MAX_LINE_WIDTH = sbl_pkg::MAX_LINE_WIDTH_DEF,
  parameter int ROW_COUNT_BITS = sbl_pkg::ROW_COUNT_BITS_DEF,
  localparam int COL_W   = $clog2(MAX_LINE_WIDTH),
  localparam int CFG_W   = COL_W + 1,
  localparam int OUT_RAW = sbl_pkg::MAG_W + COL_W + ROW_COUNT_BITS,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sbl_pkg::PIXEL_W-1:0]    in_tdata,   // pixel
  input  logic                           in_tuser,   // frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // edge_magnitude, centre_column, centre_row
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sbl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sbl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int PW = sbl_pkg::PIXEL_W;
  localparam int RW = ROW_COUNT_BITS;

  logic [CFG_W-1:0] line_width_r, eff_width;
  logic [COL_W-1:0] col_cnt_r, col_cur;
  logic [RW-1:0]    row_cnt_r, row_cur;
  logic             in_xfer, emit, adv, wrap;

  logic             s1_v_r, s1_emit_r;
  logic [PW-1:0]    s1_px_r;
  logic [COL_W-1:0] s1_idx_r, s1_ccol_r;
  logic [RW-1:0]    s1_crow_r;

  logic [PW-1:0]    upper_rd, middle_rd;
  logic [sbl_pkg::MAG_W-1:0] mag;

  logic             out_v_r;
  logic [OUT_W-1:0] out_data_r;

  // configuration
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= CFG_W'(sbl_pkg::LINE_WIDTH_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr == sbl_pkg::REG_LINE_WIDTH) begin
      line_width_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == sbl_pkg::REG_LINE_WIDTH) ?
                      sbl_pkg::CFG_DATA_W'(line_width_r) : '0;

  always_comb begin
    if (line_width_r < CFG_W'(sbl_pkg::LINE_WIDTH_MIN)) begin
      eff_width = CFG_W'(sbl_pkg::LINE_WIDTH_MIN);
    end else if (line_width_r > CFG_W'(MAX_LINE_WIDTH)) begin
      eff_width = CFG_W'(MAX_LINE_WIDTH);
    end else begin
      eff_width = line_width_r;
    end
  end

  // position counters
  assign in_xfer = in_tvalid && in_tready;
  assign col_cur = in_tuser ? '0 : col_cnt_r;
  assign row_cur = in_tuser ? '0 : row_cnt_r;
  assign emit    = (col_cur >= COL_W'(sbl_pkg::WINDOW_FIRST))
                && (row_cur >= RW'(sbl_pkg::WINDOW_FIRST));
  assign wrap    = (CFG_W'(col_cur) + CFG_W'(1)) >= eff_width;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_xfer) begin
      if (wrap) begin
        col_cnt_r <= '0;
        row_cnt_r <= (&row_cur) ? row_cur : row_cur + RW'(1);
      end else begin
        col_cnt_r <= col_cur + COL_W'(1);
        row_cnt_r <= row_cur;
      end
    end
  end

  // window stage
  assign adv       = s1_v_r && (!s1_emit_r || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_emit_r <= emit;
      s1_px_r   <= in_tdata;
      s1_idx_r  <= col_cur;
      s1_ccol_r <= col_cur - COL_W'(1);
      s1_crow_r <= row_cur - RW'(1);
    end
  end

  sbl_ram #(.WIDTH(PW), .DEPTH(MAX_LINE_WIDTH)) u_upper (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_idx_r),
    .wdata (middle_rd),
    .re    (in_xfer),
    .raddr (col_cur),
    .rdata (upper_rd)
  );

  sbl_ram #(.WIDTH(PW), .DEPTH(MAX_LINE_WIDTH)) u_middle (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_idx_r),
    .wdata (s1_px_r),
    .re    (in_xfer),
    .raddr (col_cur),
    .rdata (middle_rd)
  );

  sbl_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (adv),
    .upper     (upper_rd),
    .middle    (middle_rd),
    .pixel     (s1_px_r),
    .magnitude (mag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && s1_emit_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_emit_r) begin
      out_data_r <= OUT_W'({s1_crow_r, s1_ccol_r, mag});
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/sbl_checker.sv
// port level checks for the sobel edge magnitude block
module sbl_checker #(
  parameter int MAX_LINE_WIDTH = sbl_pkg::MAX_LINE_WIDTH_DEF,
  parameter int ROW_COUNT_BITS = sbl_pkg::ROW_COUNT_BITS_DEF,
  localparam int COL_W   = $clog2(MAX_LINE_WIDTH),
  localparam int OUT_RAW = sbl_pkg::MAG_W + COL_W + ROW_COUNT_BITS,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int COL_LO = sbl_pkg::MAG_W;
  localparam int ROW_LO = sbl_pkg::MAG_W + COL_W;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  a_centre_col_inner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[COL_LO +: COL_W] != '0)
    else $error("result for a border column");

  a_centre_row_inner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ROW_LO +: ROW_COUNT_BITS] != '0)
    else $error("result for a border row");

endmodule

bind sobel_edge_magnitude sbl_checker #(
  .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
  .ROW_COUNT_BITS (ROW_COUNT_BITS)
) u_sbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sobel_edge_magnitude_tb.sv
// self-checking testbench for the sobel edge magnitude block
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

  localparam int ROW_LIMIT     = (1 << sbl_pkg::ROW_COUNT_BITS_DEF) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 100;
  localparam int RANDOM_PIXELS = 1150;
  localparam int WIDE_RAW      = 2047;
  localparam int WIDE_PIXELS   = 120;

  typedef enum logic {OP_PIXEL, OP_WIDTH} step_kind_t;
  typedef enum logic [1:0] {PACE_NONE, PACE_LIGHT, PACE_FULL} pace_t;
  typedef enum logic [1:0] {TEX_NOISE, TEX_BINARY, TEX_FLAT} texture_t;

  typedef struct packed {
    logic [sbl_pkg::MAG_W-1:0] magnitude;
    logic [9:0]                column;
    logic [11:0]               row;
  } edge_result_t;

  typedef struct {
    step_kind_t kind;
    int         value;
    bit         sof;
    bit         pinned;
    int         magnitude;
  } directed_step_t;

  directed_step_t directed_steps [0:25] = '{
    '{OP_WIDTH, 3, 1'b0, 1'b0, 0},
    // vertical edge, no frame start after reset
    '{OP_PIXEL, 0, 1'b0, 1'b0, 0}, '{OP_PIXEL, 0, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 255, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 0, 1'b0, 1'b0, 0}, '{OP_PIXEL, 0, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 255, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 0, 1'b0, 1'b0, 0}, '{OP_PIXEL, 0, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 255, 1'b0, 1'b1, sbl_pkg::MAG_MAX},
    '{OP_PIXEL, 10, 1'b0, 1'b0, 0}, '{OP_PIXEL, 20, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 30, 1'b0, 1'b0, 0},
    // width below range
    '{OP_WIDTH, 0, 1'b0, 1'b0, 0},
    // horizontal edge in a new frame
    '{OP_PIXEL, 255, 1'b1, 1'b0, 0}, '{OP_PIXEL, 255, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 255, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 0, 1'b0, 1'b0, 0}, '{OP_PIXEL, 0, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 0, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 0, 1'b0, 1'b0, 0}, '{OP_PIXEL, 0, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 0, 1'b0, 1'b1, sbl_pkg::MAG_MAX},
    '{OP_PIXEL, 1, 1'b0, 1'b0, 0}, '{OP_PIXEL, 2, 1'b0, 1'b0, 0},
    '{OP_PIXEL, 3, 1'b0, 1'b0, 0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [sbl_pkg::PIXEL_W-1:0]    in_tdata;   // pixel
  logic                           in_tuser;   // frame_start
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [31:0]                    out_tdata;  // edge_magnitude, centre_column, centre_row
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [sbl_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  logic [sbl_pkg::PIXEL_W-1:0] upper_line [sbl_pkg::MAX_LINE_WIDTH_DEF];
  logic [sbl_pkg::PIXEL_W-1:0] middle_line [sbl_pkg::MAX_LINE_WIDTH_DEF];
  logic [sbl_pkg::PIXEL_W-1:0] window [9];
  int                          col_next;
  int                          row_next;
  logic [10:0]                 width_reg;
  edge_result_t                expected_edges [$];
  int                          fault_count;
  pace_t                       pace;
  int                          stall_left;

  sobel_edge_magnitude dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int effective_width();
    int w;
    w = int'(width_reg);
    if (w < sbl_pkg::LINE_WIDTH_MIN) w = sbl_pkg::LINE_WIDTH_MIN;
    if (w > sbl_pkg::MAX_LINE_WIDTH_DEF) w = sbl_pkg::MAX_LINE_WIDTH_DEF;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    case (pace)
      PACE_NONE:  return 0;
      PACE_LIGHT: return (r < 80) ? 0 : $urandom_range(1, 3);
      default: begin
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
      end
    endcase
  endfunction

  function automatic logic [sbl_pkg::PIXEL_W-1:0] pick_pixel(texture_t tex, int base);
    case (tex)
      TEX_NOISE:  return sbl_pkg::PIXEL_W'($urandom_range(0, 255));
      TEX_BINARY: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default:    return sbl_pkg::PIXEL_W'(base + $urandom_range(0, 3));
    endcase
  endfunction

  // window slide and gradient for one transferred pixel
  task automatic predict_edge_magnitude(input logic [sbl_pkg::PIXEL_W-1:0] px,
                                        input logic sof,
                                        input bit pinned, input int pinned_mag);
    int           col;
    int           row;
    int           gx;
    int           gy;
    int           mag;
    int           c [9];
    logic [7:0]   up;
    logic [7:0]   mid;
    edge_result_t res;
    if (sof) begin
      col_next = 0;
      row_next = 0;
    end
    col = col_next;
    row = row_next;
    up  = upper_line[col];
    mid = middle_line[col];
    upper_line[col]  = mid;
    middle_line[col] = px;
    for (int k = 0; k < 3; k++) begin
      window[k*3]     = window[k*3 + 1];
      window[k*3 + 1] = window[k*3 + 2];
    end
    window[2] = up;
    window[5] = mid;
    window[8] = px;
    if (col >= sbl_pkg::WINDOW_FIRST && row >= sbl_pkg::WINDOW_FIRST) begin
      foreach (c[k]) c[k] = int'(window[k]);
      gx  = (c[2] + 2*c[5] + c[8]) - (c[0] + 2*c[3] + c[6]);
      gy  = (c[6] + 2*c[7] + c[8]) - (c[0] + 2*c[1] + c[2]);
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > sbl_pkg::MAG_MAX) mag = sbl_pkg::MAG_MAX;
      res.magnitude = sbl_pkg::MAG_W'(pinned ? pinned_mag : mag);
      res.column    = 10'(col - 1);
      res.row       = 12'(row - 1);
      expected_edges.push_back(res);
    end else if (pinned) begin
      $display("%0t: pinned result expected but window incomplete at col %0d row %0d",
               $time, col, row);
      fault_count++;
    end
    if (col + 1 >= effective_width()) begin
      col_next = 0;
      if (row_next < ROW_LIMIT) row_next++;
    end else begin
      col_next = col + 1;
    end
  endtask

  task automatic send_pixel(input logic [sbl_pkg::PIXEL_W-1:0] px, input logic sof,
                            input bit pinned = 1'b0, input int pinned_mag = 0);
    repeat (pick_gap()) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = px;
    in_tuser  = sof;
    do @(posedge clk); while (!in_tready);
    predict_edge_magnitude(px, sof, pinned, pinned_mag);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (expected_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_line_width(input logic [10:0] want);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = sbl_pkg::REG_LINE_WIDTH;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {21'b0, want}) begin
      $display("%0t: line_width read expected %0d actual %0d", $time, want, cfg_prdata);
      fault_count++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_line_width(input int value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = sbl_pkg::REG_LINE_WIDTH;
    cfg_pwdata  = {21'b0, value[10:0]};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    width_reg = value[10:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    check_line_width(value[10:0]);
  endtask

  always @(negedge clk) begin : result_pacing
    int g;
    g = pick_gap();
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (g == 0) begin
      out_tready = 1'b1;
    end else begin
      out_tready = 1'b0;
      stall_left = g - 1;
    end
  end

  always @(posedge clk) begin
    edge_result_t got;
    edge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.magnitude = out_tdata[7:0];
      got.column    = out_tdata[17:8];
      got.row       = out_tdata[29:18];
      if (expected_edges.size() == 0) begin
        if (fault_count < MAX_REPORTS)
          $display("%0t: unexpected transfer mag %0d col %0d row %0d",
                   $time, got.magnitude, got.column, got.row);
        fault_count++;
      end else begin
        want = expected_edges.pop_front();
        if (got.magnitude !== want.magnitude || got.column !== want.column ||
            got.row !== want.row) begin
          if (fault_count < MAX_REPORTS)
            $display("%0t: expected mag %0d col %0d row %0d, actual mag %0d col %0d row %0d",
                     $time, want.magnitude, want.column, want.row,
                     got.magnitude, got.column, got.row);
          fault_count++;
        end
      end
    end
  end

  initial begin
    int       w;
    int       len;
    int       narrow_at;
    int       base;
    int       sent;
    int       r;
    int       frame_no;
    texture_t tex;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    fault_count = 0;
    stall_left  = 0;
    pace        = PACE_FULL;
    col_next    = 0;
    row_next    = 0;
    width_reg   = 11'(sbl_pkg::LINE_WIDTH_RESET);
    foreach (upper_line[k]) begin
      upper_line[k]  = '0;
      middle_line[k] = '0;
    end
    foreach (window[k]) window[k] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    check_line_width(11'(sbl_pkg::LINE_WIDTH_RESET));

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == OP_WIDTH) begin
        drain_results();
        set_line_width(directed_steps[i].value);
      end else begin
        send_pixel(directed_steps[i].value[7:0], directed_steps[i].sof,
                   directed_steps[i].pinned, directed_steps[i].magnitude);
      end
    end

    // random frames, mostly small widths, some cut short, some narrowed mid-row
    sent     = 0;
    frame_no = 0;
    while (sent < RANDOM_PIXELS) begin
      pace = ($urandom_range(3) == 0) ? PACE_NONE : PACE_FULL;
      if (frame_no == 0 || $urandom_range(1) == 1) begin
        r = $urandom_range(19);
        drain_results();
        if (r < 13)      set_line_width($urandom_range(3, 10));
        else if (r < 17) set_line_width($urandom_range(11, 64));
        else             set_line_width($urandom_range(0, 2));
      end
      w    = effective_width();
      len  = ($urandom_range(7) == 0) ? $urandom_range(1, 2*w) : $urandom_range(2*w + 1, 6*w);
      if (len > RANDOM_PIXELS - sent) len = RANDOM_PIXELS - sent;
      tex  = texture_t'($urandom_range(2));
      base = $urandom_range(0, 252);
      narrow_at = -1;
      if (w > sbl_pkg::LINE_WIDTH_MIN && len > 2*w + 2 && $urandom_range(2) == 0)
        narrow_at = $urandom_range(2*w + 1, len - 1);
      for (int p = 0; p < len; p++) begin
        if (p == narrow_at) begin
          drain_results();
          set_line_width($urandom_range(0, effective_width() - 1));
        end
        send_pixel(pick_pixel(tex, base), p == 0);
      end
      sent += len;
      frame_no++;
    end

    // width above range, short frame on the widest line
    pace = PACE_LIGHT;
    drain_results();
    set_line_width(WIDE_RAW);
    for (int p = 0; p < WIDE_PIXELS; p++)
      send_pixel(pick_pixel(TEX_NOISE, 0), p == 0);

    in_tvalid = 1'b0;
    while (expected_edges.size() != 0) @(negedge clk);
    repeat (4*SETTLE_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
